// ----- rtl/set_mean_and_std_deviation_macros.svh -----
// ----------------------------------------------------------------------------
// set_mean_and_std_deviation assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef SET_MEAN_AND_STD_DEVIATION_MACROS_SVH
`define SET_MEAN_AND_STD_DEVIATION_MACROS_SVH

// condition implies consequence in the same cycle
`define SMSD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define SMSD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/smsd_pkg.sv -----
// ----------------------------------------------------------------------------
// smsd_pkg
// widths and defaults shared by the mean and deviation datapath
// ----------------------------------------------------------------------------
`default_nettype none

package smsd_pkg;

    // field widths
    localparam int SAMPLE_W = 24;
    localparam int STD_W    = 31;
    localparam int MEAN_W   = 32;
    localparam int CNT_W    = 8;

    // accumulator widths
    localparam int SUM_W = 32;
    localparam int SQ_W  = 54;

    // parameter defaults
    localparam int MAX_COUNT_DEF   = 128;
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int FRAC_BITS_DEF   = 8;
    localparam int FRAC_MAX        = 8;

    // serial units
    localparam int DIFF_W  = SQ_W + CNT_W;
    localparam int MUL_A_W = SQ_W;
    localparam int MUL_B_W = SUM_W;
    localparam int NN_W    = 2 * CNT_W - 1;
    localparam int DIV_N_W = DIFF_W + 2 * FRAC_MAX;
    localparam int ROOT_W  = 32;
    localparam int VAR_W   = 2 * ROOT_W;

    typedef logic [SUM_W-1:0] sum_t;

endpackage

`default_nettype wire

// ----- rtl/smsd_mul.sv -----
// ----------------------------------------------------------------------------
// smsd_mul
// unsigned shift-add multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module smsd_mul
    import smsd_pkg::*;
#(
    parameter int A_W = MUL_A_W,
    parameter int B_W = MUL_B_W
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [A_W-1:0]     a,
    input  logic [B_W-1:0]     b,
    output logic               done,
    output logic [A_W+B_W-1:0] prod
);

    localparam int CW = $clog2(B_W);

    logic               busy_reg;
    logic               busy_next;
    logic               done_reg;
    logic               done_next;
    logic [CW-1:0]      cnt_reg;
    logic [CW-1:0]      cnt_next;
    logic [A_W-1:0]     a_reg;
    logic [A_W-1:0]     a_next;
    logic [A_W+B_W-1:0] p_reg;
    logic [A_W+B_W-1:0] p_next;
    logic [A_W:0]       acc;

    always_comb
    begin
        acc       = {1'b0, p_reg[A_W+B_W-1:B_W]} + (p_reg[0] ? {1'b0, a_reg} : '0);
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        p_next    = p_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            a_next    = a;
            p_next    = {{A_W{1'b0}}, b};
        end
        else if (busy_reg)
        begin
            // add the partial product on the low bit, then shift right
            p_next   = {acc, p_reg[B_W-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(B_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        p_reg <= p_next;
    end

    assign done = done_reg;
    assign prod = p_reg;

endmodule

`default_nettype wire

// ----- rtl/smsd_div.sv -----
// ----------------------------------------------------------------------------
// smsd_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module smsd_div
    import smsd_pkg::*;
#(
    parameter int N_W = DIV_N_W,
    parameter int D_W = NN_W
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [N_W-1:0] dividend,
    input  logic [D_W-1:0] divisor,
    output logic           done,
    output logic [N_W-1:0] quotient,
    output logic [D_W-1:0] remainder
);

    localparam int CW = $clog2(N_W);

    logic           busy_reg;
    logic           busy_next;
    logic           done_reg;
    logic           done_next;
    logic [CW-1:0]  cnt_reg;
    logic [CW-1:0]  cnt_next;
    logic [D_W-1:0] d_reg;
    logic [D_W-1:0] d_next;
    logic [D_W-1:0] rem_reg;
    logic [D_W-1:0] rem_next;
    logic [N_W-1:0] quo_reg;
    logic [N_W-1:0] quo_next;
    logic [D_W:0]   trial;
    logic [D_W:0]   diff;
    logic           ge;

    always_comb
    begin
        // bring down the next dividend bit and try the subtract
        trial     = {rem_reg, quo_reg[N_W-1]};
        diff      = trial - {1'b0, d_reg};
        ge        = (trial >= {1'b0, d_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        d_next    = d_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            d_next    = divisor;
            rem_next  = '0;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[D_W-1:0] : trial[D_W-1:0];
            quo_next = {quo_reg[N_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(N_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg   <= d_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ----- rtl/set_mean_and_std_deviation.sv -----
// accumulated sample: item_stall holds until the 32-step shift-add squarer is done
// dropped sample past the full count: flagged as overflow, no arithmetic, no stall unless marked
// marked sample: after the squarer, or at once if it is dropped, the result follows the 78-step
//   mean divide, two 32-step products, the 78-step variance divide and a 32-step bit-pair square root
// one set at a time; the next set is taken once the result sits in the output register
// rst_n clears the accumulators, the control state and the result valid at once
// ----------------------------------------------------------------------------
// set_mean_and_std_deviation
// running count, sum and sum of squares with a serial mean and deviation finish
// ----------------------------------------------------------------------------
`default_nettype none
`include "set_mean_and_std_deviation_macros.svh"

module set_mean_and_std_deviation
    import smsd_pkg::*;
#(
    parameter int MAX_COUNT   = MAX_COUNT_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    output logic                       item_stall,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic                       last,
    output logic                       result_valid,
    input  logic                       result_stall,
    output logic [STD_W-1:0]           std_dev,
    output logic signed [MEAN_W-1:0]   mean,
    output logic [CNT_W-1:0]           set_size,
    output logic                       overflowed
);

    localparam int EXT_SH = SAMPLE_W - SAMPLE_BITS;
    localparam int STEP_W = $clog2(ROOT_W);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SQ   = 4'd1;
    localparam logic [3:0] ST_FIN  = 4'd2;
    localparam logic [3:0] ST_MEAN = 4'd3;
    localparam logic [3:0] ST_MA   = 4'd4;
    localparam logic [3:0] ST_MB   = 4'd5;
    localparam logic [3:0] ST_VAR  = 4'd6;
    localparam logic [3:0] ST_SQRT = 4'd7;
    localparam logic [3:0] ST_OUT  = 4'd8;

    logic [3:0]          state_reg;
    logic [3:0]          state_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    sum_t                sum_reg;
    sum_t                sum_next;
    logic [SQ_W-1:0]     sq_reg;
    logic [SQ_W-1:0]     sq_next;
    logic                drop_reg;
    logic                drop_next;
    logic                last_reg;
    logic                last_next;
    logic [DIFF_W-1:0]   a_reg;
    logic [DIFF_W-1:0]   a_next;
    logic [MEAN_W-1:0]   mean_calc_reg;
    logic [MEAN_W-1:0]   mean_calc_next;
    logic [VAR_W-1:0]    rad_reg;
    logic [VAR_W-1:0]    rad_next;
    logic [ROOT_W+1:0]   rem_sq_reg;
    logic [ROOT_W+1:0]   rem_sq_next;
    logic [ROOT_W-1:0]   root_reg;
    logic [ROOT_W-1:0]   root_next;
    logic [STEP_W-1:0]   step_reg;
    logic [STEP_W-1:0]   step_next;
    logic                result_valid_reg;
    logic                result_valid_next;
    logic [STD_W-1:0]    std_reg;
    logic [STD_W-1:0]    std_next;
    logic [MEAN_W-1:0]   mean_reg;
    logic [MEAN_W-1:0]   mean_next;
    logic [CNT_W-1:0]    size_reg;
    logic [CNT_W-1:0]    size_next;
    logic                ovf_reg;
    logic                ovf_next;

    logic                        item_acc;
    logic signed [SAMPLE_W-1:0]  s_sh;
    logic signed [SAMPLE_W-1:0]  s_ext;
    logic [SAMPLE_W-1:0]         smag;
    sum_t                        v_ext;
    sum_t                        mag_sum;
    logic [2*CNT_W-1:0]          cnt_ext;
    logic [2*CNT_W-1:0]          nn_full;
    logic [DIFF_W-1:0]           b_val;
    logic [DIFF_W-1:0]           diff_val;
    logic [MEAN_W:0]             q_up;
    logic [MEAN_W:0]             q_neg;
    logic [ROOT_W+3:0]           rem_sh;
    logic [ROOT_W+3:0]           trial;
    logic [ROOT_W+3:0]           rem_sub;
    logic                        root_ge;

    logic                        mul_start;
    logic [MUL_A_W-1:0]          mul_a;
    logic [MUL_B_W-1:0]          mul_b;
    logic                        mul_done;
    logic [MUL_A_W+MUL_B_W-1:0]  mul_prod;
    logic                        div_start;
    logic [DIV_N_W-1:0]          div_n;
    logic [NN_W-1:0]             div_d;
    logic                        div_done;
    logic [DIV_N_W-1:0]          div_quo;
    logic [NN_W-1:0]             div_rem;

    logic                        full_req;
    logic                        out_load;
    logic                        out_clear;
    logic                        div_phase;
    logic                        mul_phase;

    smsd_mul #(
        .A_W (MUL_A_W),
        .B_W (MUL_B_W)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    smsd_div #(
        .N_W (DIV_N_W),
        .D_W (NN_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_n),
        .divisor   (div_d),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign item_stall = (state_reg != ST_IDLE);
    assign item_acc   = item_valid && !item_stall;

    always_comb
    begin
        // only the low sample bits count, sign-extended
        s_sh  = sample <<< EXT_SH;
        s_ext = s_sh >>> EXT_SH;
        smag  = s_ext[SAMPLE_W-1] ? (~s_ext + 1'b1) : s_ext;
        v_ext = {{(SUM_W-SAMPLE_W){s_ext[SAMPLE_W-1]}}, s_ext};

        mag_sum  = sum_reg[SUM_W-1] ? (~sum_reg + 1'b1) : sum_reg;
        cnt_ext  = {{CNT_W{1'b0}}, count_reg};
        nn_full  = cnt_ext * cnt_ext;
        b_val    = mul_prod[DIFF_W-1:0];
        diff_val = (a_reg >= b_val) ? (a_reg - b_val) : '0;

        // floor toward minus infinity for a negative sum
        q_up  = {1'b0, div_quo[MEAN_W-1:0]} + {{MEAN_W{1'b0}}, (div_rem != '0)};
        q_neg = ~q_up + 1'b1;

        // one root bit per cycle from the next radicand bit pair
        rem_sh  = {rem_sq_reg, rad_reg[VAR_W-1 -: 2]};
        trial   = {2'b00, root_reg, 2'b01};
        root_ge = (rem_sh >= trial);
        rem_sub = rem_sh - trial;
    end

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        sum_next          = sum_reg;
        sq_next           = sq_reg;
        drop_next         = drop_reg;
        last_next         = last_reg;
        a_next            = a_reg;
        mean_calc_next    = mean_calc_reg;
        rad_next          = rad_reg;
        rem_sq_next       = rem_sq_reg;
        root_next         = root_reg;
        step_next         = step_reg;
        result_valid_next = result_valid_reg;
        std_next          = std_reg;
        mean_next         = mean_reg;
        size_next         = size_reg;
        ovf_next          = ovf_reg;
        mul_start         = 1'b0;
        mul_a             = '0;
        mul_b             = '0;
        div_start         = 1'b0;
        div_n             = '0;
        div_d             = '0;

        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (item_acc)
                begin
                    last_next = last;
                    if (count_reg < CNT_W'(MAX_COUNT))
                    begin
                        sum_next   = sum_reg + v_ext;
                        count_next = count_reg + 1'b1;
                        mul_start  = 1'b1;
                        mul_a      = MUL_A_W'(smag);
                        mul_b      = MUL_B_W'(smag);
                        state_next = ST_SQ;
                    end
                    else
                    begin
                        drop_next = 1'b1;
                        if (last)
                        begin
                            state_next = ST_FIN;
                        end
                    end
                end
            end
            ST_SQ:
            begin
                if (mul_done)
                begin
                    sq_next    = sq_reg + mul_prod[SQ_W-1:0];
                    state_next = last_reg ? ST_FIN : ST_IDLE;
                end
            end
            ST_FIN:
            begin
                if (count_reg == '0)
                begin
                    mean_calc_next = '0;
                    root_next      = '0;
                    state_next     = ST_OUT;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_n      = DIV_N_W'(mag_sum) << FRAC_BITS;
                    div_d      = NN_W'(count_reg);
                    state_next = ST_MEAN;
                end
            end
            ST_MEAN:
            begin
                if (div_done)
                begin
                    mean_calc_next = sum_reg[SUM_W-1] ? q_neg[MEAN_W-1:0]
                                                      : div_quo[MEAN_W-1:0];
                    mul_start  = 1'b1;
                    mul_a      = sq_reg;
                    mul_b      = MUL_B_W'(count_reg);
                    state_next = ST_MA;
                end
            end
            ST_MA:
            begin
                if (mul_done)
                begin
                    a_next     = mul_prod[DIFF_W-1:0];
                    mul_start  = 1'b1;
                    mul_a      = MUL_A_W'(mag_sum);
                    mul_b      = mag_sum;
                    state_next = ST_MB;
                end
            end
            ST_MB:
            begin
                if (mul_done)
                begin
                    div_start  = 1'b1;
                    div_n      = DIV_N_W'(diff_val) << (2 * FRAC_BITS);
                    div_d      = NN_W'(nn_full);
                    state_next = ST_VAR;
                end
            end
            ST_VAR:
            begin
                if (div_done)
                begin
                    rad_next    = div_quo[VAR_W-1:0];
                    rem_sq_next = '0;
                    root_next   = '0;
                    step_next   = '0;
                    state_next  = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                rem_sq_next = root_ge ? rem_sub[ROOT_W+1:0] : rem_sh[ROOT_W+1:0];
                root_next   = {root_reg[ROOT_W-2:0], root_ge};
                rad_next    = {rad_reg[VAR_W-3:0], 2'b00};
                step_next   = step_reg + 1'b1;
                if (step_reg == STEP_W'(ROOT_W - 1))
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_valid_next = 1'b1;
                    std_next          = root_reg[STD_W-1:0];
                    mean_next         = mean_calc_reg;
                    size_next         = count_reg;
                    ovf_next          = drop_reg;
                    count_next        = '0;
                    sum_next          = '0;
                    sq_next           = '0;
                    drop_next         = 1'b0;
                    last_next         = 1'b0;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            count_reg        <= '0;
            sum_reg          <= '0;
            sq_reg           <= '0;
            drop_reg         <= 1'b0;
            last_reg         <= 1'b0;
            step_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            sum_reg          <= sum_next;
            sq_reg           <= sq_next;
            drop_reg         <= drop_next;
            last_reg         <= last_next;
            step_reg         <= step_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg         <= a_next;
        mean_calc_reg <= mean_calc_next;
        rad_reg       <= rad_next;
        rem_sq_reg    <= rem_sq_next;
        root_reg      <= root_next;
        std_reg       <= std_next;
        mean_reg      <= mean_next;
        size_reg      <= size_next;
        ovf_reg       <= ovf_next;
    end

    assign result_valid = result_valid_reg;
    assign std_dev      = std_reg;
    assign mean         = mean_reg;
    assign set_size     = size_reg;
    assign overflowed   = ovf_reg;

    assign full_req  = item_acc && (count_reg == CNT_W'(MAX_COUNT));
    assign out_load  = (state_reg == ST_OUT) && (!result_valid_reg || !result_stall);
    assign out_clear = result_valid_reg && (state_reg == ST_IDLE) && (count_reg == '0)
                       && !drop_reg;
    assign div_phase = (state_reg == ST_MEAN) || (state_reg == ST_VAR);
    assign mul_phase = (state_reg == ST_SQ) || (state_reg == ST_MA) || (state_reg == ST_MB);

    `SMSD_ASSERT_NXT(a_full_drop, full_req, drop_reg, "request past the full count not flagged")
    `SMSD_ASSERT_NXT(a_out_load, out_load, out_clear, "result load did not clear the set")
    `SMSD_ASSERT_IMP(a_div_phase, div_done, div_phase, "divider finished outside a divide phase")
    `SMSD_ASSERT_IMP(a_mul_phase, mul_done, mul_phase, "multiplier finished outside a product phase")

endmodule

`default_nettype wire
